@@ src/fdvp_pkg.sv @@
// Shared constants and types for the FCM/DFCM value predictor.
package fdvp_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int HASH_W        = $clog2(TABLE_ENTRIES);
  localparam int VALUE_W       = 64;
  localparam int HASH_SHIFT    = 5;
  localparam int TAG_SHIFT     = 50;
  localparam int MODE_W        = 2;

  // Predictor mode codes; the unused code behaves as DFCM
  localparam logic [MODE_W-1:0] MODE_LAST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FCM  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DFCM = 2'd2;

  // State update request from the stream control
  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] sample;
  } fdvp_upd_t;

  // Engine status back to the stream control
  typedef struct packed {
    logic               ready;
    logic [VALUE_W-1:0] pred;
  } fdvp_stat_t;

endpackage

@@ src/fcm_dfcm_value_predictor_unit.sv @@
// Top level of the streaming FCM/DFCM value predictor.
//
//   channel  direction  handshake          payload
//   s_*      in         s_tvalid/s_tready  s_tdata[63:0] sample_value
//   m_*      out        m_tvalid/m_tready  m_tdata[63:0] prediction_before,
//                                          m_tdata[127:64] prediction_after
//   cfg_*    in         cfg_valid/cfg_ready cfg_data[1:0] predictor_mode
//
// One item per cycle sustained while the output moves; items pass the middle
// stage and then the output register. The after-prediction is formed from the
// registered table read of the next hash; same-entry collisions resolve by
// forwarding. Reset (rst, synchronous) starts a zero sweep of all 1024 entries;
// s_tready stays low during it, cfg writes are taken at any time outside reset.
// A stalled output holds its result; one more item is taken into the pipe.
module fcm_dfcm_value_predictor_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [63:0]                 s_tdata,   // [63:0] sample_value
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [127:0]                m_tdata,   // [63:0] prediction_before,
                                                 // [127:64] prediction_after
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fdvp_pkg::MODE_W-1:0] cfg_data   // [1:0] predictor_mode
);

  import fdvp_pkg::*;

  logic [MODE_W-1:0]  mode;
  fdvp_upd_t          upd;
  fdvp_stat_t         stat;
  logic               in_acc;
  logic               s1_valid;
  logic               s1_adv;
  logic [VALUE_W-1:0] s1_before;

  // Mode register: take writes whenever out of reset
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_DFCM;
    end else if (cfg_valid && cfg_ready) begin
      mode <= cfg_data;
    end
  end

  // Input handshake: a stalled item in the middle stage blocks state updates
  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = stat.ready && (!s1_valid || s1_adv);
  assign in_acc   = s_tvalid && s_tready;

  assign upd.valid  = in_acc;
  assign upd.sample = s_tdata;

  fdvp_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .mode (mode),
    .upd  (upd),
    .stat (stat)
  );

  // Middle stage: hold the before-prediction until the item moves to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_acc || (s1_valid && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_before <= stat.pred;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tdata <= {stat.pred, s1_before};
    end
  end

endmodule

@@ src/fdvp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fdvp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port (old data on a same-address collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/fdvp_engine.sv @@
// Predictor state: history table, context hash, last value, forwarding and clear.
module fdvp_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [fdvp_pkg::MODE_W-1:0]  mode,
  input  fdvp_pkg::fdvp_upd_t          upd,
  output fdvp_pkg::fdvp_stat_t         stat
);

  import fdvp_pkg::*;

  logic [HASH_W-1:0]         hash;
  logic [HASH_W-1:0]         hash_next;
  logic [VALUE_W-1:0]        prev;
  logic [VALUE_W-1:0]        ent_reg;
  logic [VALUE_W-1:0]        ent;
  logic                      rd_pending;
  logic                      fwd_hit;
  logic [VALUE_W-1:0]        fwd_val;
  logic [VALUE_W-1:0]        stored;
  logic [VALUE_W-1:0]        pred;
  logic [HASH_W+HASH_SHIFT-1:0] hash_shl;
  logic                      upd_tbl;
  logic                      clear_busy;
  logic [HASH_W-1:0]         clear_addr;
  logic                      ram_we;
  logic [HASH_W-1:0]         ram_waddr;
  logic [VALUE_W-1:0]        ram_wdata;
  logic [VALUE_W-1:0]        ram_rdata;

  // Table entry at the current hash: fresh read, forwarded write, or held copy
  always_comb begin
    if (rd_pending) begin
      ent = fwd_hit ? fwd_val : ram_rdata;
    end else begin
      ent = ent_reg;
    end
  end

  // Prediction from the current state
  always_comb begin
    case (mode)
      MODE_LAST: pred = prev;
      MODE_FCM:  pred = ent;
      default:   pred = ent + prev;
    endcase
  end

  // Entry to store and the following hash
  assign stored    = (mode == MODE_FCM) ? upd.sample : (upd.sample - prev);
  assign hash_shl  = {hash, {HASH_SHIFT{1'b0}}};
  assign hash_next = hash_shl[HASH_W-1:0] ^ HASH_W'(stored >> TAG_SHIFT);
  assign upd_tbl   = upd.valid && (mode != MODE_LAST);

  // Memory port muxing: zero sweep after reset, then item writes
  assign ram_we    = clear_busy || upd_tbl;
  assign ram_waddr = clear_busy ? clear_addr : hash;
  assign ram_wdata = clear_busy ? '0 : stored;

  fdvp_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (hash_next),
    .rdata (ram_rdata)
  );

  // Clear sweep over every table entry after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clear_addr <= '0;
    end else if (clear_busy) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == HASH_W'(TABLE_ENTRIES - 1)) begin
        clear_busy <= 1'b0;
      end
    end
  end

  // Advance hash and last value, track the outstanding read
  always_ff @(posedge clk) begin
    if (rst) begin
      hash       <= '0;
      prev       <= '0;
      ent_reg    <= '0;
      rd_pending <= 1'b0;
    end else begin
      if (upd.valid) begin
        prev <= upd.sample;
      end
      if (upd_tbl) begin
        hash <= hash_next;
      end
      rd_pending <= upd_tbl;
      if (rd_pending) begin
        ent_reg <= ent;
      end
    end
  end

  // Forward the write when the new hash hits the entry just written
  always_ff @(posedge clk) begin
    if (upd_tbl) begin
      fwd_hit <= (hash_next == hash);
      fwd_val <= stored;
    end
  end

  assign stat.ready = !clear_busy;
  assign stat.pred  = pred;

endmodule

@@ src/fdvp_checker.sv @@
// Port-level checks for the value predictor, bound to the top level.
module fdvp_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [127:0] m_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // A new result follows an accepted item through the middle and output registers
  a_out_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without matching item");

  // Reset starts the table sweep and empties the output
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("input open or output valid right after reset");

  // Full pipe with a stalled output takes no item until the output moves
  a_stall_block: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready && !s_tready |=> m_tready || !s_tready)
    else $error("item taken while pipe is full");

endmodule

bind fcm_dfcm_value_predictor_unit fdvp_checker u_fdvp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ verif/tb_fcm_dfcm_value_predictor_unit.sv @@
// Self-checking testbench for the streaming FCM/DFCM value predictor unit.
module tb_fcm_dfcm_value_predictor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import fdvp_pkg::*;

  // The spare mode code, decoded by the block as DFCM
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int MAX_SHOWN = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 140;

  typedef struct {
    bit [VALUE_W-1:0] prior;
    bit [VALUE_W-1:0] after;
  } pred_pair_t;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [63:0]        s_tdata;   // [63:0] sample_value
  logic               m_tvalid;
  logic               m_tready;
  logic [127:0]       m_tdata;   // [63:0] prediction_before, [127:64] prediction_after
  logic               cfg_valid;
  logic               cfg_ready;
  logic [MODE_W-1:0]  cfg_data;  // [1:0] predictor_mode

  fcm_dfcm_value_predictor_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Predictor state, mirrored from the block
  bit [VALUE_W-1:0] hist_tbl [TABLE_ENTRIES];
  bit [HASH_W-1:0]  ctx_hash;
  bit [VALUE_W-1:0] last_val;
  bit [MODE_W-1:0]  cur_mode;

  bit [VALUE_W-1:0] sample_q [$];
  pred_pair_t       pred_q [$];
  int               queued_cnt;
  int               sent_cnt;
  int               cfg_cnt;
  int               err_cnt;
  bit               s_took;
  int               s_gap;
  int               s_calm;
  int               m_stall;
  int               m_calm;

  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    foreach (hist_tbl[i]) hist_tbl[i] = '0;
    ctx_hash   = '0;
    last_val   = '0;
    cur_mode   = MODE_DFCM;
    queued_cnt = 0;
    sent_cnt   = 0;
    cfg_cnt    = 0;
    err_cnt    = 0;
    s_took     = 1'b0;
    s_gap      = 0;
    s_calm     = 0;
    m_stall    = 0;
    m_calm     = 0;
  end

  always #5 clk = ~clk;

  // Prediction from the current state
  function bit [VALUE_W-1:0] guess_next();
    case (cur_mode)
      MODE_LAST: guess_next = last_val;
      MODE_FCM:  guess_next = hist_tbl[ctx_hash];
      default:   guess_next = hist_tbl[ctx_hash] + last_val;
    endcase
  endfunction

  // Advance the predictor by one sample and return both predictions
  function pred_pair_t advance_predictor(bit [VALUE_W-1:0] v);
    pred_pair_t       p;
    bit [VALUE_W-1:0] stored;
    bit [VALUE_W-1:0] mix;
    p.prior = guess_next();
    if (cur_mode != MODE_LAST) begin
      stored = (cur_mode == MODE_FCM) ? v : v - last_val;
      hist_tbl[ctx_hash] = stored;
      mix = ({{(VALUE_W-HASH_W){1'b0}}, ctx_hash} << HASH_SHIFT) ^ (stored >> TAG_SHIFT);
      ctx_hash = mix[HASH_W-1:0];
    end
    last_val = v;
    p.after = guess_next();
    return p;
  endfunction

  // Idle length: mostly none or short, a few long, with calm stretches
  function int draw_gap(inout int calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    if (r < 3) calm = $urandom_range(30, 120);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function void flag_mismatch(string what, bit [VALUE_W-1:0] exp_v, bit [VALUE_W-1:0] got_v);
    if (err_cnt < MAX_SHOWN)
      $display("mismatch on %s at %0t: expected %h, got %h", what, $realtime, exp_v, got_v);
    err_cnt++;
  endfunction

  // Sample handshakes, track config, check results, predict accepted items
  always @(posedge clk) begin
    pred_pair_t exp_p;
    s_took = !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        cur_mode = cfg_data;
        cfg_cnt++;
      end
      if (m_tvalid && m_tready) begin
        if (pred_q.size() == 0) begin
          flag_mismatch("unexpected item", '0, m_tdata[63:0]);
        end else begin
          exp_p = pred_q.pop_front();
          if (m_tdata[63:0] !== exp_p.prior)
            flag_mismatch("prediction_before", exp_p.prior, m_tdata[63:0]);
          if (m_tdata[127:64] !== exp_p.after)
            flag_mismatch("prediction_after", exp_p.after, m_tdata[127:64]);
        end
      end
      if (s_took) begin
        pred_q.insert(pred_q.size(), advance_predictor(s_tdata));
        sent_cnt++;
      end
    end
  end

  // Source: hold an item until taken, then idle for the drawn gap
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !s_took) begin
      s_tvalid <= 1'b1;
    end else if (s_gap > 0) begin
      s_tvalid <= 1'b0;
      s_gap--;
    end else if (sample_q.size() > 0) begin
      s_tvalid <= 1'b1;
      s_tdata  <= sample_q.pop_front();
      s_gap = draw_gap(s_calm);
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Sink: stall the result side at random
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (m_stall > 0) begin
      m_tready <= 1'b0;
      m_stall--;
    end else begin
      m_tready <= 1'b1;
      m_stall = draw_gap(m_calm);
    end
  end

  task automatic queue_sample(bit [VALUE_W-1:0] v);
    sample_q.insert(sample_q.size(), v);
    queued_cnt++;
  endtask

  // Wait until every item is taken and every result has come back
  task automatic drain();
    while (sent_cnt != queued_cnt || pred_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(bit [MODE_W-1:0] mode);
    int target;
    target = cfg_cnt + 1;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    while (cfg_cnt != target) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One run of samples: random, strided, periodic or constant
  task automatic queue_run(int len);
    bit [VALUE_W-1:0] base;
    bit [VALUE_W-1:0] stride;
    bit [VALUE_W-1:0] pat [8];
    int               period;
    int               kind;
    kind   = $urandom_range(0, 9);
    base   = {$urandom(), $urandom()};
    period = $urandom_range(1, 8);
    if ($urandom_range(0, 3) == 0) stride = {$urandom(), $urandom()};
    else stride = VALUE_W'(signed'($urandom_range(0, 64)) - 32);
    foreach (pat[i]) begin
      pat[i] = {$urandom(), $urandom()};
      if ($urandom_range(0, 1) == 1) pat[i] = pat[i] >> $urandom_range(1, 63);
    end
    for (int i = 0; i < len; i++) begin
      if (kind < 2) queue_sample({$urandom(), $urandom()});
      else if (kind < 5) queue_sample(base + stride * i);
      else if (kind < 9) queue_sample(pat[i % period]);
      else queue_sample(base);
    end
  endtask

  // Stimulus: directed items per mode, then random phases
  initial begin
    int phase_end;
    bit [MODE_W-1:0] mode;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Reset mode (DFCM): field extremes and alternating bits
    queue_sample(64'h0);
    queue_sample(64'hFFFF_FFFF_FFFF_FFFF);
    queue_sample(64'h1);
    queue_sample(64'h8000_0000_0000_0000);
    queue_sample(64'h5555_5555_5555_5555);
    queue_sample(64'hAAAA_AAAA_AAAA_AAAA);
    drain();

    // Last value continues from the shared state
    write_mode(MODE_LAST);
    queue_sample(64'h7);
    queue_sample(64'h7);
    queue_sample(64'hFFFF_FFFF_FFFF_FFFF);
    drain();

    // FCM on a repeating pair so the table hits
    write_mode(MODE_FCM);
    for (int i = 0; i < 6; i++) queue_sample((i % 2 == 0) ? 64'd10 : 64'd20);
    drain();

    // Spare code acts as DFCM: a constant stride
    write_mode(MODE_SPARE);
    for (int i = 1; i <= 5; i++) queue_sample(64'd100 * i);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) mode = MODE_LAST;
      else if (ph == 1) mode = MODE_SPARE;
      else if (ph == 2) mode = MODE_DFCM;
      else if (ph == 3) mode = MODE_FCM;
      else mode = MODE_W'($urandom_range(0, 3));
      write_mode(mode);
      phase_end = queued_cnt + PHASE_ITEMS;
      while (queued_cnt < phase_end) queue_run($urandom_range(4, 40));
      drain();
    end

    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ sim.f @@
src/fdvp_pkg.sv
src/fdvp_ram.sv
src/fdvp_engine.sv
src/fcm_dfcm_value_predictor_unit.sv
src/fdvp_checker.sv
verif/tb_fcm_dfcm_value_predictor_unit.sv
